/* rtl/matrix3_inverse_assert.svh */
// assertion macros for the matrix3_inverse block
// used by rtl/matrix3_inverse.sv, no other dependencies
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH
`ifndef ASSERT_OFF
// property that must hold at every edge out of reset
`define M3INV_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("m3inv: property failed");
// condition that must hold in the cycle after a trigger
`define M3INV_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("m3inv: next-cycle property failed");
`else
`define M3INV_ASSERT(label, clk, rst_n, prop)
`define M3INV_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* rtl/m3inv_pkg.sv */
// shared constants and types for the matrix3_inverse block
// no dependencies
`default_nettype none
package m3inv_pkg;
	localparam int IO_W          = 32;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int N_ELEM         = 9;

	// per-element side flags that travel with the division
	typedef struct packed {
		logic neg;
		logic ov;
	} m3inv_flags_t;
endpackage
`default_nettype wire

/* rtl/m3inv_mat_if.sv */
// input channel: one 3x3 matrix per beat
// depends on m3inv_pkg
`default_nettype none
interface m3inv_mat_if;
	import m3inv_pkg::*;
	logic            valid;
	logic            ready;
	logic [IO_W-1:0] in_r0c0;
	logic [IO_W-1:0] in_r0c1;
	logic [IO_W-1:0] in_r0c2;
	logic [IO_W-1:0] in_r1c0;
	logic [IO_W-1:0] in_r1c1;
	logic [IO_W-1:0] in_r1c2;
	logic [IO_W-1:0] in_r2c0;
	logic [IO_W-1:0] in_r2c1;
	logic [IO_W-1:0] in_r2c2;

	modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
		in_r2c0, in_r2c1, in_r2c2, input ready);
	modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
		in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface
`default_nettype wire

/* rtl/m3inv_res_if.sv */
// output channel: one inverse matrix with flags per beat
// depends on m3inv_pkg
`default_nettype none
interface m3inv_res_if;
	import m3inv_pkg::*;
	logic            valid;
	logic            ready;
	logic [IO_W-1:0] inv_r0c0;
	logic [IO_W-1:0] inv_r0c1;
	logic [IO_W-1:0] inv_r0c2;
	logic [IO_W-1:0] inv_r1c0;
	logic [IO_W-1:0] inv_r1c1;
	logic [IO_W-1:0] inv_r1c2;
	logic [IO_W-1:0] inv_r2c0;
	logic [IO_W-1:0] inv_r2c1;
	logic [IO_W-1:0] inv_r2c2;
	logic            singular;
	logic            saturated;

	modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
		inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated, input ready);
	modport sink (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
		inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated, output ready);
endinterface
`default_nettype wire

/* rtl/m3inv_divider.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on m3inv_pkg
`default_nettype none
module m3inv_divider #(
	parameter int DW   = 32,
	parameter int DIVW = 131
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [DIVW-1:0]           num_i,
	input  wire logic [DIVW-1:0]           den_i,
	input  wire m3inv_pkg::m3inv_flags_t   flags_i,
	output logic      [DW-1:0]             quo_o,
	output m3inv_pkg::m3inv_flags_t        flags_o
);
	import m3inv_pkg::*;

	logic [DIVW-1:0] rem_st [DW];
	logic [DIVW-1:0] den_st [DW];
	logic [DW-1:0]   quo_st [DW];
	m3inv_flags_t    flg_st [DW];

	// stage k decides quotient bit DW-1-k
	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [DIVW-1:0] rem_in, den_in, den_sh;
		logic [DW-1:0]   quo_in;
		m3inv_flags_t    flg_in;
		logic            take;

		if (k == 0) begin : g_first
			assign rem_in = num_i;
			assign den_in = den_i;
			assign quo_in = '0;
			assign flg_in = flags_i;
		end else begin : g_next
			assign rem_in = rem_st[k-1];
			assign den_in = den_st[k-1];
			assign quo_in = quo_st[k-1];
			assign flg_in = flg_st[k-1];
		end

		assign den_sh = den_in << (DW-1-k);
		assign take   = (rem_in >= den_sh);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[k] <= take ? (rem_in - den_sh) : rem_in;
				den_st[k] <= den_in;
				quo_st[k] <= quo_in | (DW'(take) << (DW-1-k));
				flg_st[k] <= flg_in;
			end
		end
	end

	assign quo_o   = quo_st[DW-1];
	assign flags_o = flg_st[DW-1];
endmodule
`default_nettype wire

/* rtl/matrix3_inverse.sv */
// top level of the 3x3 fixed-point matrix inverse
// depends on m3inv_pkg, m3inv_mat_if, m3inv_res_if, m3inv_divider, matrix3_inverse_assert.svh
//
// usage
// - mat carries one matrix per beat, nine signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS
//   elements in the low DATA_WIDTH bits of each field
// - res carries the inverse per beat, each element sign-extended to 32 bits, with
//   singular (zero determinant, all elements zero) and saturated (some element clipped)
// - one matrix per cycle sustained while res takes every beat; the pipeline has
//   seven arithmetic stages (products, cofactors, determinant partials and sum,
//   magnitudes, range check), one stage per quotient bit in the nine dividers,
//   and the output register
// - the whole pipeline advances together; while res holds a beat that is not taken,
//   every stage holds and mat.ready is low, nothing is dropped or repeated
// - bubbles advance through the pipeline whenever the output register is empty or taken
// - reset clears the valid bits only; the data registers are not reset
`default_nettype none
`include "matrix3_inverse_assert.svh"
module matrix3_inverse #(
	parameter int DATA_WIDTH = m3inv_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	m3inv_mat_if.sink  mat,
	m3inv_res_if.source res
);
	import m3inv_pkg::*;

	localparam int DW   = DATA_WIDTH;
	localparam int PW   = 2*DW;
	localparam int CW   = 2*DW + 1;
	localparam int PPW  = 2*DW + 1;
	localparam int DETW = 3*DW + 3;
	localparam int NUMW = 2*DW + 1 + 2*FRAC_BITS;
	localparam int DSW  = 4*DW + 3;
	localparam int DIVW = (NUMW > DSW) ? NUMW : DSW;
	localparam int NST  = DW + 8;

	// operand indexes (a, b, c, d) for cofactor a*b - c*d, elements row-major
	localparam int unsigned COF_IDX [N_ELEM][4] = '{
		'{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
		'{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
	};

	logic                  en;
	logic [NST-1:0]        v_q;
	logic signed [DW-1:0]  x [N_ELEM];

	// global advance: output empty or being taken
	assign en        = !v_q[NST-1] || res.ready;
	assign mat.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NST-2:0], mat.valid};
		end
	end

	// input elements, low DATA_WIDTH bits
	assign x[0] = signed'(mat.in_r0c0[DW-1:0]);
	assign x[1] = signed'(mat.in_r0c1[DW-1:0]);
	assign x[2] = signed'(mat.in_r0c2[DW-1:0]);
	assign x[3] = signed'(mat.in_r1c0[DW-1:0]);
	assign x[4] = signed'(mat.in_r1c1[DW-1:0]);
	assign x[5] = signed'(mat.in_r1c2[DW-1:0]);
	assign x[6] = signed'(mat.in_r2c0[DW-1:0]);
	assign x[7] = signed'(mat.in_r2c1[DW-1:0]);
	assign x[8] = signed'(mat.in_r2c2[DW-1:0]);

	logic signed [PW-1:0]   pa_s1 [N_ELEM];
	logic signed [PW-1:0]   pb_s1 [N_ELEM];
	logic signed [DW-1:0]   x0_s1 [3];
	logic signed [DW-1:0]   x0_s2 [3];
	logic signed [CW-1:0]   cof_s2 [N_ELEM];
	logic signed [CW-1:0]   cof_s3 [N_ELEM];
	logic signed [CW-1:0]   cof_s4 [N_ELEM];
	logic signed [CW-1:0]   cof_s5 [N_ELEM];
	logic signed [PPW-1:0]  plo_s3 [3];
	logic signed [PPW-1:0]  phi_s3 [3];
	logic signed [DETW-1:0] term_s4 [3];
	logic signed [DETW-1:0] det_s5;
	logic [DIVW-1:0]        num_s6 [N_ELEM];
	logic [DIVW-1:0]        den_s6;
	logic [N_ELEM-1:0]      neg_s6;
	logic                   zero_s6;
	logic [DIVW-1:0]        num_s7 [N_ELEM];
	logic [DIVW-1:0]        den_s7;
	m3inv_flags_t           flg_s7 [N_ELEM];
	logic                   zero_s7;
	logic [DW-1:0]          zero_dq;
	logic [DW-1:0]          quo [N_ELEM];
	m3inv_flags_t           flg_d [N_ELEM];
	logic signed [DW-1:0]   inv_s8 [N_ELEM];
	logic                   sing_s8;
	logic                   sat_s8;
	logic signed [DW-1:0]   inv_nx [N_ELEM];
	logic [N_ELEM-1:0]      sat_nx;

	// stage 1: the eighteen element products
	for (genvar i = 0; i < N_ELEM; i++) begin : g_s1
		always_ff @(posedge clk) begin
			if (en) begin
				pa_s1[i] <= x[COF_IDX[i][0]] * x[COF_IDX[i][1]];
				pb_s1[i] <= x[COF_IDX[i][2]] * x[COF_IDX[i][3]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x0_s1 <= '{x[0], x[1], x[2]};
			x0_s2 <= x0_s1;
		end
	end

	// stage 2: cofactors
	for (genvar i = 0; i < N_ELEM; i++) begin : g_s2
		always_ff @(posedge clk) begin
			if (en) begin
				cof_s2[i] <= CW'(pa_s1[i]) - CW'(pb_s1[i]);
				cof_s3[i] <= cof_s2[i];
				cof_s4[i] <= cof_s3[i];
				cof_s5[i] <= cof_s4[i];
			end
		end
	end

	// stages 3 and 4: first-row expansion, cofactor split into low and high halves
	for (genvar j = 0; j < 3; j++) begin : g_det
		logic signed [CW-1:0] yc;
		logic signed [DW:0]   ylo, yhi;
		assign yc  = cof_s2[3*j];
		assign ylo = signed'({1'b0, yc[DW-1:0]});
		assign yhi = signed'(yc[CW-1:DW]);
		always_ff @(posedge clk) begin
			if (en) begin
				plo_s3[j]  <= x0_s2[j] * ylo;
				phi_s3[j]  <= x0_s2[j] * yhi;
				term_s4[j] <= (DETW'(phi_s3[j]) <<< DW) + DETW'(plo_s3[j]);
			end
		end
	end

	// stage 5: determinant
	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
		end
	end

	// stage 6: magnitudes, scaled numerators and result signs
	always_ff @(posedge clk) begin
		if (en) begin
			den_s6  <= DIVW'(det_s5[DETW-1] ? unsigned'(-det_s5) : unsigned'(det_s5));
			zero_s6 <= (det_s5 == '0);
		end
	end

	for (genvar i = 0; i < N_ELEM; i++) begin : g_s6
		logic [CW-1:0] mag;
		assign mag = cof_s5[i][CW-1] ? unsigned'(-cof_s5[i]) : unsigned'(cof_s5[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				num_s6[i] <= DIVW'(mag) << (2*FRAC_BITS);
				neg_s6[i] <= cof_s5[i][CW-1] ^ det_s5[DETW-1];
			end
		end
	end

	// stage 7: quotient too wide for DATA_WIDTH bits
	for (genvar i = 0; i < N_ELEM; i++) begin : g_s7
		always_ff @(posedge clk) begin
			if (en) begin
				num_s7[i]     <= num_s6[i];
				flg_s7[i].neg <= neg_s6[i];
				flg_s7[i].ov  <= (num_s6[i] >= (den_s6 << DW));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s7  <= den_s6;
			zero_s7 <= zero_s6;
			zero_dq <= {zero_dq[DW-2:0], zero_s7};
		end
	end

	// quotient bits, one per stage
	for (genvar i = 0; i < N_ELEM; i++) begin : g_div
		m3inv_divider #(
			.DW   (DW),
			.DIVW (DIVW)
		) u_div (
			.clk     (clk),
			.en      (en),
			.num_i   (num_s7[i]),
			.den_i   (den_s7),
			.flags_i (flg_s7[i]),
			.quo_o   (quo[i]),
			.flags_o (flg_d[i])
		);
	end

	// sign, saturation and singular handling
	for (genvar i = 0; i < N_ELEM; i++) begin : g_fin
		logic big_neg, big_pos;
		assign big_neg = flg_d[i].ov || (quo[i][DW-1] && (quo[i][DW-2:0] != '0));
		assign big_pos = flg_d[i].ov || quo[i][DW-1];
		always_comb begin
			sat_nx[i] = 1'b0;
			if (zero_dq[DW-1]) begin
				inv_nx[i] = '0;
			end else if (flg_d[i].neg) begin
				sat_nx[i] = big_neg;
				inv_nx[i] = big_neg ? signed'({1'b1, {(DW-1){1'b0}}}) : signed'(-quo[i]);
			end else begin
				sat_nx[i] = big_pos;
				inv_nx[i] = big_pos ? signed'({1'b0, {(DW-1){1'b1}}}) : signed'(quo[i]);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s8  <= inv_nx;
			sing_s8 <= zero_dq[DW-1];
			sat_s8  <= |sat_nx;
		end
	end

	assign res.valid     = v_q[NST-1];
	assign res.inv_r0c0  = IO_W'(inv_s8[0]);
	assign res.inv_r0c1  = IO_W'(inv_s8[1]);
	assign res.inv_r0c2  = IO_W'(inv_s8[2]);
	assign res.inv_r1c0  = IO_W'(inv_s8[3]);
	assign res.inv_r1c1  = IO_W'(inv_s8[4]);
	assign res.inv_r1c2  = IO_W'(inv_s8[5]);
	assign res.inv_r2c0  = IO_W'(inv_s8[6]);
	assign res.inv_r2c1  = IO_W'(inv_s8[7]);
	assign res.inv_r2c2  = IO_W'(inv_s8[8]);
	assign res.singular  = sing_s8;
	assign res.saturated = sat_s8;

	// checks
	`M3INV_ASSERT(a_sing_no_sat, clk, arst_n, (res.valid && res.singular) |-> !res.saturated)
	`M3INV_ASSERT(a_sing_zero, clk, arst_n, (res.valid && res.singular) |-> (res.inv_r0c0 == 0 && res.inv_r1c1 == 0 && res.inv_r2c2 == 0))
	`M3INV_ASSERT_NEXT(a_stall_hold, clk, arst_n, !mat.ready, $stable(v_q))
endmodule
`default_nettype wire
